@@ sv/bvo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bvo_pkg;

  localparam int CoordBits  = 24;
  localparam int SqBits     = 2 * CoordBits;
  localparam int SumBits    = SqBits + 2;
  localparam int CfgIdxBits = 3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   diff_t;

  typedef enum logic {
    KindBox    = 1'b0,
    KindSphere = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgRefKind = 3'd0,
    CfgRefLoX  = 3'd1,
    CfgRefLoY  = 3'd2,
    CfgRefLoZ  = 3'd3,
    CfgRefHiX  = 3'd4,
    CfgRefHiY  = 3'd5,
    CfgRefHiZ  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    kind_e  query_kind;
    coord_t q_lo_x;
    coord_t q_lo_y;
    coord_t q_lo_z;
    coord_t q_hi_x;
    coord_t q_hi_y;
    coord_t q_hi_z;
  } query_t;

  typedef struct packed {
    logic overlaps;
    logic encloses;
    logic same_volume;
  } result_t;

  // One volume as the geometry stage sees it; index 0 is x.
  typedef struct packed {
    kind_e            kind;
    logic [2:0][CoordBits-1:0] lo;
    logic [2:0][CoordBits-1:0] hi;
  } volume_t;

  // Everything the compare stage needs: the linear tests already resolved
  // and the squared terms of the distance tests.
  typedef struct packed {
    kind_e                  rk;
    kind_e                  qk;
    logic                   ov_box;
    logic                   en_box;
    logic                   en_sib;
    logic                   gap_pos;
    logic                   same;
    logic [2:0][SqBits-1:0] sq_a;
    logic [2:0][SqBits-1:0] sq_b;
    logic [2:0][SqBits-1:0] sq_c;
    logic [SqBits-1:0]      sq_rsum;
    logic [SqBits-1:0]      sq_gap;
    logic [SqBits-1:0]      sq_rad;
  } sq_stage_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    coord_diff = diff_t'(a) - diff_t'(b);
  endfunction

  function automatic logic [CoordBits:0] diff_mag(input diff_t d);
    diff_mag = d[CoordBits] ? (~d + 1'b1) : d;
  endfunction

  // The magnitude of any coordinate difference stays below 2**CoordBits.
  function automatic logic [SqBits-1:0] sq_mag(input diff_t d);
    logic [CoordBits:0]   m;
    logic [CoordBits-1:0] mm;
    m      = diff_mag(d);
    mm     = m[CoordBits-1:0];
    sq_mag = {{CoordBits{1'b0}}, mm} * {{CoordBits{1'b0}}, mm};
  endfunction

endpackage

`default_nettype wire

@@ sv/bvo_square_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bvo_square_stage (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire bvo_pkg::volume_t   ref_i,
  input  wire bvo_pkg::volume_t   query_i,
  output bvo_pkg::sq_stage_t      stage_o
);
  import bvo_pkg::*;

  localparam int WideBits = CoordBits + 3;

  typedef logic signed [WideBits-1:0] wide_t;

  sq_stage_t stage_d;
  sq_stage_t stage_q;

  always_comb begin
    coord_t rlo [3];
    coord_t rhi [3];
    coord_t qlo [3];
    coord_t qhi [3];
    coord_t rr;
    coord_t qr;
    coord_t rad;
    coord_t c;
    coord_t blo;
    coord_t bhi;
    coord_t p;
    diff_t  gap;
    wide_t  cdist;
    wide_t  cmag;
    wide_t  ext;
    logic   lo_in;
    logic   hi_in;
    logic   sib_ok;
    logic   eq;
    logic   ov;

    for (int i = 0; i < 3; i++) begin
      rlo[i] = ref_i.lo[i];
      rhi[i] = ref_i.hi[i];
      qlo[i] = query_i.lo[i];
      qhi[i] = query_i.hi[i];
    end

    // A negative sphere radius counts as zero in every test.
    if (ref_i.kind == KindSphere && rhi[0] < 0) begin
      rhi[0] = '0;
    end
    if (query_i.kind == KindSphere && qhi[0] < 0) begin
      qhi[0] = '0;
    end
    rr = rhi[0];
    qr = qhi[0];

    ov     = 1'b1;
    lo_in  = 1'b1;
    hi_in  = 1'b1;
    sib_ok = 1'b1;
    eq     = (ref_i.kind == query_i.kind) && (rhi[0] == qhi[0]);
    if (ref_i.kind == KindBox && (rhi[1] != qhi[1] || rhi[2] != qhi[2])) begin
      eq = 1'b0;
    end

    // The sphere of a mixed pair is clamped against the other volume's box.
    rad = (ref_i.kind == KindSphere) ? rr : qr;

    for (int i = 0; i < 3; i++) begin
      cdist = wide_t'(rlo[i]) + wide_t'(rhi[i]) - wide_t'(qlo[i]) - wide_t'(qhi[i]);
      cmag  = cdist[WideBits-1] ? -cdist : cdist;
      ext   = (wide_t'(rhi[i]) - wide_t'(rlo[i])) + (wide_t'(qhi[i]) - wide_t'(qlo[i]));
      if (cmag > ext) begin
        ov = 1'b0;
      end

      if (qlo[i] < rlo[i] || qlo[i] > rhi[i]) begin
        lo_in = 1'b0;
      end
      if (qhi[i] < rlo[i] || qhi[i] > rhi[i]) begin
        hi_in = 1'b0;
      end

      if (diff_mag(coord_diff(rhi[i], qlo[i])) < {1'b0, qr} ||
          diff_mag(coord_diff(qlo[i], rlo[i])) < {1'b0, qr}) begin
        sib_ok = 1'b0;
      end

      if (rlo[i] != qlo[i]) begin
        eq = 1'b0;
      end

      if (ref_i.kind == KindSphere) begin
        c   = rlo[i];
        blo = qlo[i];
        bhi = qhi[i];
      end else begin
        c   = qlo[i];
        blo = rlo[i];
        bhi = rhi[i];
      end
      p = (c > bhi) ? bhi : c;
      p = (p < blo) ? blo : p;

      stage_d.sq_a[i] = sq_mag(coord_diff(rlo[i], qlo[i]));
      stage_d.sq_b[i] = sq_mag(coord_diff(rlo[i], qhi[i]));
      stage_d.sq_c[i] = sq_mag(coord_diff(p, c));
    end

    gap = coord_diff(rr, qr);

    stage_d.rk      = ref_i.kind;
    stage_d.qk      = query_i.kind;
    stage_d.ov_box  = ov;
    stage_d.en_box  = lo_in & hi_in;
    stage_d.en_sib  = lo_in & sib_ok;
    stage_d.gap_pos = !gap[CoordBits] && (gap != '0);
    stage_d.same    = eq;
    stage_d.sq_rsum = sq_mag(diff_t'(rr) + diff_t'(qr));
    stage_d.sq_gap  = sq_mag(gap);
    stage_d.sq_rad  = sq_mag(diff_t'(rad));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ sv/bvo_decide_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bvo_decide_stage (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire bvo_pkg::sq_stage_t  stage_i,
  output bvo_pkg::result_t         result_o
);
  import bvo_pkg::*;

  typedef logic [SumBits-1:0] sum_t;

  sum_t    sum_a;
  sum_t    sum_b;
  sum_t    sum_c;
  sum_t    rsum2;
  sum_t    gap2;
  sum_t    rad2;
  result_t result_d;
  result_t result_q;

  assign sum_a = sum_t'(stage_i.sq_a[0]) + sum_t'(stage_i.sq_a[1]) + sum_t'(stage_i.sq_a[2]);
  assign sum_b = sum_t'(stage_i.sq_b[0]) + sum_t'(stage_i.sq_b[1]) + sum_t'(stage_i.sq_b[2]);
  assign sum_c = sum_t'(stage_i.sq_c[0]) + sum_t'(stage_i.sq_c[1]) + sum_t'(stage_i.sq_c[2]);
  assign rsum2 = sum_t'(stage_i.sq_rsum);
  assign gap2  = sum_t'(stage_i.sq_gap);
  assign rad2  = sum_t'(stage_i.sq_rad);

  always_comb begin
    // When the reference is a sphere, rad2 holds its squared radius.
    if (stage_i.rk == KindBox && stage_i.qk == KindBox) begin
      result_d.overlaps = stage_i.ov_box;
    end else if (stage_i.rk == KindSphere && stage_i.qk == KindSphere) begin
      result_d.overlaps = (sum_a <= rsum2);
    end else begin
      result_d.overlaps = (sum_c < rad2);
    end

    if (stage_i.qk == KindBox) begin
      if (stage_i.rk == KindBox) begin
        result_d.encloses = stage_i.en_box;
      end else begin
        result_d.encloses = (sum_a <= rad2) && (sum_b <= rad2);
      end
    end else if (stage_i.rk == KindSphere) begin
      result_d.encloses = stage_i.gap_pos && (sum_a < gap2);
    end else begin
      result_d.encloses = stage_i.en_sib;
    end

    result_d.same_volume = stage_i.same;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

@@ sv/bounding_volume_overlap_test.sv @@
// A query passes through the input, squaring and result registers before
// out_valid_o rises. Throughput: one query per cycle while out_stall_i is low;
// each register advances whenever the stage after it is empty or moving.
// Reset clears all valid flags and sets every reference register to zero
// (box with both corners at the origin).
`timescale 1ns / 1ps
`default_nettype none

module bounding_volume_overlap_test (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire bvo_pkg::query_t                     in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output bvo_pkg::result_t                         out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [bvo_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  wire logic [bvo_pkg::CoordBits-1:0]       cfg_wdata_i
);
  import bvo_pkg::*;

  logic                       ref_kind_q;
  logic [2:0][CoordBits-1:0]  ref_lo_q;
  logic [2:0][CoordBits-1:0]  ref_hi_q;

  query_t    query_q;
  logic      v0_q, v0_d;
  logic      v1_q, v1_d;
  logic      v2_q, v2_d;
  logic      en0, en1, en2;
  volume_t   ref_vol;
  volume_t   query_vol;
  sq_stage_t stage;

  // Reference registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_kind_q <= 1'b0;
      ref_lo_q   <= '0;
      ref_hi_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRefKind: ref_kind_q  <= cfg_wdata_i[0];
        CfgRefLoX:  ref_lo_q[0] <= cfg_wdata_i;
        CfgRefLoY:  ref_lo_q[1] <= cfg_wdata_i;
        CfgRefLoZ:  ref_lo_q[2] <= cfg_wdata_i;
        CfgRefHiX:  ref_hi_q[0] <= cfg_wdata_i;
        CfgRefHiY:  ref_hi_q[1] <= cfg_wdata_i;
        CfgRefHiZ:  ref_hi_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its content
  // moves on in the same cycle.
  assign en2        = ~v2_q | ~out_stall_i;
  assign en1        = ~v1_q | en2;
  assign en0        = ~v0_q | en1;
  assign in_stall_o = ~en0;

  always_comb begin
    v0_d = en0 ? in_valid_i : v0_q;
    v1_d = en1 ? v0_q : v1_q;
    v2_d = en2 ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      query_q <= in_data_i;
    end
  end

  always_comb begin
    ref_vol.kind   = kind_e'(ref_kind_q);
    ref_vol.lo     = ref_lo_q;
    ref_vol.hi     = ref_hi_q;
    query_vol.kind = query_q.query_kind;
    query_vol.lo   = {query_q.q_lo_z, query_q.q_lo_y, query_q.q_lo_x};
    query_vol.hi   = {query_q.q_hi_z, query_q.q_hi_y, query_q.q_hi_x};
  end

  bvo_square_stage u_square (
    .clk_i   (clk_i),
    .en_i    (en1),
    .ref_i   (ref_vol),
    .query_i (query_vol),
    .stage_o (stage)
  );

  bvo_decide_stage u_decide (
    .clk_i    (clk_i),
    .en_i     (en2),
    .stage_i  (stage),
    .result_o (out_data_o)
  );

  assign out_valid_o = v2_q;

  // A draining output lets the whole pipeline move, so no input is refused.
  a_drain_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output transaction completes");

  // A stalled output must not let the squaring stage lose its transaction.
  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && v1_q |=> v1_q && out_valid_o)
    else $error("pipeline content lost during output stall");

  // An accepted transaction always lands in the input register.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v0_q)
    else $error("accepted transaction not held in the input register");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bvo_pkg::*;

  localparam longint CoordMax = (longint'(1) << (CoordBits - 1)) - 1;
  localparam longint CoordMin = -(longint'(1) << (CoordBits - 1));
  // Index past the last register; writes to it must leave the reference alone.
  localparam logic [CfgIdxBits-1:0] CfgNoReg = 3'd7;
  localparam int QuietLimit = 5000;
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 185;

  // Predicts the three flags of every accepted query and keeps them in order.
  class flag_board;
    kind_e       ref_kind;
    coord_t      ref_lo[3];
    coord_t      ref_hi[3];
    result_t     expected_flags[$];
    int unsigned errors;

    function new();
      int i;
      ref_kind = KindBox;
      for (i = 0; i < 3; i++) begin
        ref_lo[i] = '0;
        ref_hi[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CoordBits-1:0] data);
      case (idx)
        CfgRefKind: ref_kind  = kind_e'(data[0]);
        CfgRefLoX:  ref_lo[0] = data;
        CfgRefLoY:  ref_lo[1] = data;
        CfgRefLoZ:  ref_lo[2] = data;
        CfgRefHiX:  ref_hi[0] = data;
        CfgRefHiY:  ref_hi[1] = data;
        CfgRefHiZ:  ref_hi[2] = data;
        default: ;
      endcase
    endfunction

    function longint mag(longint a);
      return (a < 0) ? -a : a;
    endfunction

    function longint dist2(longint a[3], longint b[3]);
      longint s;
      int i;
      s = 0;
      for (i = 0; i < 3; i++) s += (a[i] - b[i]) * (a[i] - b[i]);
      return s;
    endfunction

    // Squared distance from the center to the clamped closest box point,
    // compared strictly against the squared radius.
    function bit sphere_box(longint c[3], longint r, longint lo[3], longint hi[3]);
      longint s;
      longint p;
      int i;
      s = 0;
      for (i = 0; i < 3; i++) begin
        p = (c[i] < hi[i]) ? c[i] : hi[i];
        p = (lo[i] > p) ? lo[i] : p;
        s += (p - c[i]) * (p - c[i]);
      end
      return s < r * r;
    endfunction

    function bit holds_point(kind_e k, longint lo[3], longint hi[3], longint p[3]);
      int i;
      if (k == KindBox) begin
        for (i = 0; i < 3; i++)
          if (p[i] < lo[i] || p[i] > hi[i]) return 1'b0;
        return 1'b1;
      end
      return dist2(lo, p) <= hi[0] * hi[0];
    endfunction

    function result_t overlap_flags(query_t q);
      longint  rlo[3];
      longint  rhi[3];
      longint  qlo[3];
      longint  qhi[3];
      longint  gap;
      kind_e   qk;
      result_t f;
      int      i;
      qk = q.query_kind;
      for (i = 0; i < 3; i++) begin
        rlo[i] = ref_lo[i];
        rhi[i] = ref_hi[i];
      end
      qlo[0] = q.q_lo_x;
      qlo[1] = q.q_lo_y;
      qlo[2] = q.q_lo_z;
      qhi[0] = q.q_hi_x;
      qhi[1] = q.q_hi_y;
      qhi[2] = q.q_hi_z;
      if (ref_kind == KindSphere && rhi[0] < 0) rhi[0] = 0;
      if (qk == KindSphere && qhi[0] < 0) qhi[0] = 0;

      f.overlaps = 1'b1;
      if (ref_kind == KindBox && qk == KindBox) begin
        for (i = 0; i < 3; i++)
          if (mag(rlo[i] + rhi[i] - qlo[i] - qhi[i]) > (rhi[i] - rlo[i]) + (qhi[i] - qlo[i]))
            f.overlaps = 1'b0;
      end else if (ref_kind == KindSphere && qk == KindSphere) begin
        f.overlaps = dist2(rlo, qlo) <= (rhi[0] + qhi[0]) * (rhi[0] + qhi[0]);
      end else if (ref_kind == KindSphere) begin
        f.overlaps = sphere_box(rlo, rhi[0], qlo, qhi);
      end else begin
        f.overlaps = sphere_box(qlo, qhi[0], rlo, rhi);
      end

      if (qk == KindBox) begin
        f.encloses = holds_point(ref_kind, rlo, rhi, qlo) && holds_point(ref_kind, rlo, rhi, qhi);
      end else if (ref_kind == KindSphere) begin
        gap = rhi[0] - qhi[0];
        f.encloses = (gap > 0) && (dist2(rlo, qlo) < gap * gap);
      end else begin
        // Only the center and the distance to each face pair are looked at.
        f.encloses = holds_point(KindBox, rlo, rhi, qlo);
        for (i = 0; i < 3; i++)
          if (mag(rhi[i] - qlo[i]) < qhi[0] || mag(qlo[i] - rlo[i]) < qhi[0])
            f.encloses = 1'b0;
      end

      f.same_volume = (ref_kind == qk) && rlo[0] == qlo[0] && rlo[1] == qlo[1] &&
                      rlo[2] == qlo[2] && rhi[0] == qhi[0] &&
                      (ref_kind == KindSphere || (rhi[1] == qhi[1] && rhi[2] == qhi[2]));
      return f;
    endfunction

    function void note_query(query_t q);
      expected_flags.push_back(overlap_flags(q));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_flags.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: expected none, got %b%b%b", $time,
                 got.overlaps, got.encloses, got.same_volume);
        return;
      end
      want = expected_flags.pop_front();
      if (got.overlaps !== want.overlaps || got.encloses !== want.encloses ||
          got.same_volume !== want.same_volume) begin
        errors++;
        $display("%0t: flag mismatch: expected ov=%b en=%b eq=%b, got ov=%b en=%b eq=%b",
                 $time, want.overlaps, want.encloses, want.same_volume,
                 got.overlaps, got.encloses, got.same_volume);
      end
    endfunction

    function int outstanding();
      return expected_flags.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  query_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  result_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CoordBits-1:0] cfg_wdata_i;

  flag_board board;
  logic steady;
  int quiet_cycles = 0;
  longint span;
  longint center[3];
  int phase;
  int n;

  bounding_volume_overlap_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_query(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > CoordMax) return coord_t'(CoordMax);
    if (v < CoordMin) return coord_t'(CoordMin);
    return coord_t'(v);
  endfunction

  function automatic longint jitter(longint base, longint w);
    return clamp_coord(base + longint'($urandom_range(2 * w)) - w);
  endfunction

  function automatic query_t make_query(kind_e k, longint lx, longint ly, longint lz,
                                        longint hx, longint hy, longint hz);
    query_t q;
    q.query_kind = k;
    q.q_lo_x     = clamp_coord(lx);
    q.q_lo_y     = clamp_coord(ly);
    q.q_lo_z     = clamp_coord(lz);
    q.q_hi_x     = clamp_coord(hx);
    q.q_hi_y     = clamp_coord(hy);
    q.q_hi_z     = clamp_coord(hz);
    return q;
  endfunction

  // Mostly volumes scattered around the reference at its own scale, some small
  // enough to fit inside it, plus exact copies and raw noise.
  function automatic query_t random_query();
    int unsigned roll;
    longint      c[3];
    longint      e[3];
    longint      ext;
    longint      r;
    kind_e       k;
    query_t      q;
    int          i;
    roll = $urandom_range(99);
    if (roll < 8) begin
      q.query_kind = kind_e'($urandom_range(1));
      q.q_lo_x     = coord_t'($urandom);
      q.q_lo_y     = coord_t'($urandom);
      q.q_lo_z     = coord_t'($urandom);
      q.q_hi_x     = coord_t'($urandom);
      q.q_hi_y     = coord_t'($urandom);
      q.q_hi_z     = coord_t'($urandom);
      return q;
    end
    if (roll < 14) begin
      k = board.ref_kind;
      if (k == KindBox)
        return make_query(k, board.ref_lo[0], board.ref_lo[1], board.ref_lo[2],
                          board.ref_hi[0], board.ref_hi[1], board.ref_hi[2]);
      r = board.ref_hi[0];
      if (r <= 0 && $urandom_range(1) == 1) r = -longint'($urandom_range(1000));
      return make_query(k, board.ref_lo[0], board.ref_lo[1], board.ref_lo[2], r,
                        jitter(0, CoordMax), jitter(0, CoordMax));
    end
    k   = kind_e'($urandom_range(1));
    ext = ($urandom_range(1) == 1) ? span : span / 8 + 1;
    for (i = 0; i < 3; i++) begin
      c[i] = jitter(center[i], span + span / 2);
      e[i] = $urandom_range(ext);
    end
    if (k == KindSphere) begin
      r = ($urandom_range(9) == 0) ? -longint'($urandom_range(ext)) : e[0];
      return make_query(k, c[0], c[1], c[2], r, jitter(0, CoordMax), jitter(0, CoordMax));
    end
    q = make_query(k, c[0] - e[0], c[1] - e[1], c[2] - e[2], c[0] + e[0], c[1] + e[1],
                   c[2] + e[2]);
    if ($urandom_range(15) == 0) {q.q_lo_x, q.q_hi_x} = {q.q_hi_x, q.q_lo_x};
    return q;
  endfunction

  task automatic send_query(query_t q);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxBits-1:0] idx, logic [CoordBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_reference(kind_e k, longint lx, longint ly, longint lz,
                               longint hx, longint hy, longint hz);
    write_register(CfgRefKind, {{(CoordBits - 1){1'b0}}, k});
    write_register(CfgRefLoX, clamp_coord(lx));
    write_register(CfgRefLoY, clamp_coord(ly));
    write_register(CfgRefLoZ, clamp_coord(lz));
    write_register(CfgRefHiX, clamp_coord(hx));
    write_register(CfgRefHiY, clamp_coord(hy));
    write_register(CfgRefHiZ, clamp_coord(hz));
  endtask

  task automatic random_reference();
    longint c[3];
    longint e[3];
    longint r;
    int     i;
    case ($urandom_range(3))
      0: span = 16;
      1: span = 300;
      2: span = 5000;
      default: span = 1 << 21;
    endcase
    for (i = 0; i < 3; i++) begin
      center[i] = jitter(0, CoordMax);
      c[i]      = center[i];
      e[i]      = $urandom_range(span);
    end
    if ($urandom_range(1) == 0) begin
      // Now and then the y extent is given upside down.
      if ($urandom_range(7) == 0) e[1] = -e[1];
      set_reference(KindBox, c[0] - e[0], c[1] - e[1], c[2] - e[2], c[0] + e[0],
                    c[1] + e[1], c[2] + e[2]);
    end else begin
      r = ($urandom_range(7) == 0) ? -e[0] : e[0];
      set_reference(KindSphere, c[0], c[1], c[2], r, jitter(0, CoordMax), jitter(0, CoordMax));
    end
  endtask

  initial begin
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    steady      = 1'b0;
    span        = 16;
    center      = '{0, 0, 0};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reference after reset: a box collapsed onto the origin.
    send_query(make_query(KindBox, 0, 0, 0, 0, 0, 0));
    send_query(make_query(KindSphere, 0, 0, 0, 0, 0, 0));
    send_query(make_query(KindSphere, 0, 0, 0, -5, 3, -3));
    send_query(make_query(KindBox, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    send_query(make_query(KindBox, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
    send_query(make_query(KindSphere, CoordMin, CoordMin, CoordMin, CoordMax, 0, 0));
    send_query(make_query(KindSphere, CoordMax, CoordMax, CoordMax, CoordMax, CoordMin, 1));
    drain_results();

    set_reference(KindBox, -1000, -1000, -1000, 1000, 1000, 1000);
    send_query(make_query(KindBox, -10, -10, -10, 10, 10, 10));
    send_query(make_query(KindBox, 500, 500, 500, 1500, 1500, 1500));
    send_query(make_query(KindBox, 1000, 0, 0, 2000, 10, 10));
    send_query(make_query(KindBox, 1001, 0, 0, 2000, 10, 10));
    send_query(make_query(KindSphere, 0, 0, 0, 500, 0, 0));
    send_query(make_query(KindSphere, 900, 0, 0, 100, 0, 0));
    send_query(make_query(KindSphere, 900, 0, 0, 101, 0, 0));
    send_query(make_query(KindBox, -1000, -1000, -1000, 1000, 1000, 1000));
    drain_results();

    set_reference(KindSphere, 0, 0, 0, 1000, 77, -3);
    send_query(make_query(KindSphere, 0, 0, 0, -3, 0, 0));
    send_query(make_query(KindSphere, 0, 0, 0, 1000, 5, 9));
    send_query(make_query(KindSphere, 600, 0, 0, 400, 0, 0));
    send_query(make_query(KindSphere, 2000, 0, 0, 1000, 0, 0));
    send_query(make_query(KindBox, -577, -577, -577, 577, 577, 577));
    send_query(make_query(KindBox, 1000, 0, 0, 1000, 0, 0));
    drain_results();

    // A sphere with a negative radius, selected by a kind word with its upper
    // bits set, followed by a write to an index that names no register.
    set_reference(KindBox, 5, 5, 5, -7, 0, 0);
    write_register(CfgRefKind, '1);
    write_register(CfgNoReg, 24'h00abcd);
    send_query(make_query(KindSphere, 5, 5, 5, 0, 0, 0));
    send_query(make_query(KindBox, 5, 5, 5, 5, 5, 5));
    send_query(make_query(KindBox, -4, -4, -4, 20, 20, 20));

    for (phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      if (phase == 0) begin
        span   = 1 << 21;
        center = '{0, 0, 0};
        set_reference(KindBox, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
      end else if (phase == 1) begin
        span   = 5000;
        center = '{CoordMax - 2000, CoordMax - 2000, CoordMax - 2000};
        set_reference(KindSphere, CoordMax, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin);
      end else begin
        random_reference();
      end
      steady = (phase == 4);
      for (n = 0; n < PhaseItems; n++) send_query(random_query());
    end
    drain_results();
    steady = 1'b0;
    repeat (20) @(negedge clk_i);

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
